// File: hdl/smm_pkg.sv
// Package for the streaming substring matcher.
// Holds register indexes, character constants, the cell control struct and helpers.
// No dependencies.
package smm_pkg;

  localparam int CharW   = 8;
  localparam int PatBytes = 16;
  localparam int PatW    = PatBytes * CharW;
  localparam int LenW    = 5;
  localparam int ModeW   = 2;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 64;

  // register indexes on the write port
  localparam logic [CfgAddrW-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_MODE     = 2'd3;

  // match_mode bits
  localparam int MODE_FOLD_BIT  = 0;
  localparam int MODE_EXACT_BIT = 1;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_LF    = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CharW-1:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic shift;  // accepted a non-terminator char
    logic fold;   // case-insensitive compare
  } cell_ctl_t;

  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
    return r;
  endfunction

  function automatic logic is_boundary(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_NUL);
  endfunction

endpackage

// File: hdl/smm_cell.sv
// One window cell: holds one character, passes it to the next cell on a shift,
// and compares the incoming character with its pattern byte. Uses smm_pkg.
module smm_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  smm_pkg::cell_ctl_t           ctl,
  input  logic [smm_pkg::CharW-1:0]    char_in,
  input  logic [smm_pkg::PatW-1:0]     pat_all,
  input  logic [smm_pkg::LenW-1:0]     pat_len,
  output logic [smm_pkg::CharW-1:0]    char_out,
  output logic                         cmp_ok
);

  logic [smm_pkg::CharW-1:0] char_r;
  logic [3:0]                k;
  logic                      in_use;
  logic [smm_pkg::CharW-1:0] pat_b;
  logic [smm_pkg::CharW-1:0] w_cmp;
  logic [smm_pkg::CharW-1:0] p_cmp;

  // cell IDX compares the character that lines up with pattern byte len-1-IDX
  assign in_use = smm_pkg::LenW'(IDX) < pat_len;
  assign k      = 4'(pat_len - smm_pkg::LenW'(IDX) - smm_pkg::LenW'(1));
  assign pat_b  = pat_all[k*smm_pkg::CharW +: smm_pkg::CharW];

  always_comb begin
    if (ctl.fold) begin
      w_cmp = smm_pkg::fold_case(char_in);
      p_cmp = smm_pkg::fold_case(pat_b);
    end else begin
      w_cmp = char_in;
      p_cmp = pat_b;
    end
  end

  assign cmp_ok = !in_use || (w_cmp == p_cmp);

  always_ff @(posedge clk) begin
    if (ctl.shift) char_r <= char_in;
  end

  assign char_out = char_r;

endmodule

// File: hdl/substring_match_with_modes.sv
// Top level of the streaming substring matcher.
// Instantiates a row of smm_cell; uses smm_pkg.
//
// Usage:
//   in_*  : one character per word in in_tdata[7:0]; a zero word ends the string.
//   out_* : one word per string, sent for the terminator; out_tdata[0] = found.
//   cfg_* : write-only registers, index 0 pattern chars 0-7, 1 pattern chars 8-15,
//           2 pattern length, 3 match mode. Write only while the block is idle.
// Each character shifts into a row of MAX_PATTERN cells; all cells compare
// against their pattern byte in the same cycle and the results are ANDed.
// Throughput: one character per cycle while the skid register is empty, as the
// compare across the cell row is combinational. The result word for a terminator
// is registered into the output register, or into the skid register on a stall.
// The result sits in an output register backed by a one-word skid register;
// in_tready drops only while the skid register is full, so characters keep
// flowing while a result waits on a stalled receiver.
// Reset (rst_n low, synchronous) clears the configuration registers to zero, the
// string state and the valid flags of both result registers.
module substring_match_with_modes #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_code
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [0] found, [7:1] zero
  input  logic                           cfg_we,
  input  logic [smm_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [smm_pkg::CfgDataW-1:0]   cfg_wdata
);

  localparam int SeenW = $clog2(MAX_PATTERN + 1);

  // configuration
  logic [63:0]                  pat_low_r;
  logic [63:0]                  pat_high_r;
  logic [smm_pkg::LenW-1:0]     pat_len_r;
  logic [smm_pkg::ModeW-1:0]    mode_r;
  logic [smm_pkg::PatW-1:0]     pat_all;

  // string state
  logic [SeenW-1:0]             seen_r, seen_nxt;
  logic                         pending_r, pending_nxt;
  logic                         match_r, match_nxt;

  // output side
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  logic                         skid_found_r, skid_found_nxt;

  logic                         accept;
  logic                         is_term;
  logic                         push;
  logic                         match_bnd;
  logic                         hit;
  logic                         len_ok;
  smm_pkg::cell_ctl_t           ctl;
  logic [smm_pkg::CharW-1:0]    chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0]       cmp_ok;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign is_term   = in_tdata == smm_pkg::CH_NUL;
  assign push      = accept && is_term;
  assign pat_all   = {pat_high_r, pat_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      mode_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        smm_pkg::REG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        smm_pkg::REG_PAT_HIGH: pat_high_r <= cfg_wdata;
        smm_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_wdata[smm_pkg::LenW-1:0];
        smm_pkg::REG_MODE:     mode_r     <= cfg_wdata[smm_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  // cell row
  assign ctl.shift = accept && !is_term;
  assign ctl.fold  = mode_r[smm_pkg::MODE_FOLD_BIT];
  assign chain[0]  = in_tdata;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    smm_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .char_in  (chain[i]),
      .pat_all  (pat_all),
      .pat_len  (pat_len_r),
      .char_out (chain[i+1]),
      .cmp_ok   (cmp_ok[i])
    );
  end

  always_comb begin
    seen_nxt = seen_r;
    if (seen_r != SeenW'(MAX_PATTERN)) seen_nxt = seen_r + SeenW'(1);
  end

  assign len_ok = (pat_len_r != '0) &&
                  (pat_len_r <= smm_pkg::LenW'(MAX_PATTERN)) &&
                  ({{(smm_pkg::LenW+1-SeenW){1'b0}}, seen_nxt} >= {1'b0, pat_len_r});
  assign hit       = len_ok && (&cmp_ok);
  assign match_bnd = match_r || (pending_r && smm_pkg::is_boundary(in_tdata));

  // string state update
  always_comb begin
    pending_nxt = pending_r;
    match_nxt   = match_r;
    if (accept) begin
      if (is_term) begin
        pending_nxt = 1'b0;
        match_nxt   = 1'b0;
      end else if (mode_r[smm_pkg::MODE_EXACT_BIT]) begin
        pending_nxt = hit;
        match_nxt   = match_bnd;
      end else begin
        pending_nxt = 1'b0;
        match_nxt   = match_bnd || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      pending_r <= 1'b0;
      match_r   <= 1'b0;
    end else if (accept) begin
      seen_r    <= is_term ? '0 : seen_nxt;
      pending_r <= pending_nxt;
      match_r   <= match_nxt;
    end
  end

  // output register with skid behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    if (out_valid_r && !out_tready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_found_nxt = match_bnd;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_found_nxt  = skid_found_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = push;
      out_found_nxt = match_bnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    skid_found_r <= skid_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r};

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SeenW'(MAX_PATTERN))
    else $error("character count past window depth");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (seen_r == '0) && !pending_r && !match_r)
    else $error("string state not cleared after terminator");

  a_loose_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_term && !mode_r[smm_pkg::MODE_EXACT_BIT]) |=> !pending_r)
    else $error("boundary pending outside exact mode");

endmodule

// File: test/substring_match_with_modes_tb.sv
// Testbench for substring_match_with_modes: streams text words into the matcher,
// predicts the found flag of every terminator and checks each result word.
// Depends on smm_pkg and the substring_match_with_modes top level.
module substring_match_with_modes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [smm_pkg::ModeW-1:0] MODE_SENS         = 2'd0;
  localparam logic [smm_pkg::ModeW-1:0] MODE_NOCASE       = 2'd1;
  localparam logic [smm_pkg::ModeW-1:0] MODE_EXACT        = 2'd2;
  localparam logic [smm_pkg::ModeW-1:0] MODE_EXACT_NOCASE = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 1150;
  localparam int REPORT_MAX   = 10;

  // Tracks the string state of the matcher and the found flags still owed.
  class found_board;
    logic [smm_pkg::CfgDataW-1:0] pat_lo, pat_hi;
    logic [smm_pkg::LenW-1:0]     pat_len;
    logic [smm_pkg::ModeW-1:0]    mode;
    logic [smm_pkg::CharW-1:0]    win [smm_pkg::PatBytes];  // win[0] is the newest char
    int                           seen;
    bit                           pending, matched;
    bit                           found_q [$];
    int                           mismatches;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = '0;
      mode = MODE_SENS;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (win[i]) win[i] = '0;
      seen = 0;
      pending = 1'b0;
      matched = 1'b0;
    endfunction

    function void write_reg(logic [smm_pkg::CfgAddrW-1:0] idx,
                            logic [smm_pkg::CfgDataW-1:0] v);
      case (idx)
        smm_pkg::REG_PAT_LOW:  pat_lo = v;
        smm_pkg::REG_PAT_HIGH: pat_hi = v;
        smm_pkg::REG_PAT_LEN:  pat_len = v[smm_pkg::LenW-1:0];
        smm_pkg::REG_MODE:     mode = v[smm_pkg::ModeW-1:0];
        default: ;
      endcase
    endfunction

    function logic [smm_pkg::CharW-1:0] lower(logic [smm_pkg::CharW-1:0] c);
      if (c >= "A" && c <= "Z") return c ^ 8'h20;
      return c;
    endfunction

    function bit word_break(logic [smm_pkg::CharW-1:0] c);
      return c == smm_pkg::CH_SPACE || c == smm_pkg::CH_TAB || c == smm_pkg::CH_LF ||
             c == smm_pkg::CH_NUL;
    endfunction

    function bit window_hit();
      logic [smm_pkg::CharW-1:0] w, p;
      int len;
      len = pat_len;
      if (len == 0 || len > smm_pkg::PatBytes || seen < len) return 1'b0;
      for (int k = 0; k < len; k++) begin
        w = win[len - 1 - k];
        p = (k < 8) ? pat_lo[k*smm_pkg::CharW +: smm_pkg::CharW]
                    : pat_hi[(k-8)*smm_pkg::CharW +: smm_pkg::CharW];
        if (mode[smm_pkg::MODE_FOLD_BIT]) begin
          w = lower(w);
          p = lower(p);
        end
        if (w != p) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_char(logic [smm_pkg::CharW-1:0] c);
      bit hit;
      if (pending && word_break(c)) matched = 1'b1;
      if (c == smm_pkg::CH_NUL) begin
        found_q.push_back(matched);
        clear_text();
        return;
      end
      for (int i = smm_pkg::PatBytes - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = c;
      if (seen < smm_pkg::PatBytes) seen++;
      hit = window_hit();
      if (mode[smm_pkg::MODE_EXACT_BIT]) begin
        pending = hit;
      end else begin
        pending = 1'b0;
        if (hit) matched = 1'b1;
      end
    endfunction

    function void check_found(logic [7:0] data);
      logic [7:0] want;
      if (found_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result word %h with none expected", $time, data);
        return;
      end
      want = {7'd0, found_q.pop_front()};
      if (data !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: found mismatch, expected %h got %h", $time, want, data);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [7:0]                   out_tdata;
  logic                         cfg_we = 1'b0;
  logic [smm_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [smm_pkg::CfgDataW-1:0] cfg_wdata = '0;

  found_board board;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int words_sent = 0;

  substring_match_with_modes #(.MAX_PATTERN(smm_pkg::PatBytes)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] char_code
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] found
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_found(out_tdata);
  end

  // Receiver: random ready, or a long hold-off whenever the main flow asks for one.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // All drive tasks start and end just after a falling edge.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = c;
    do @(posedge clk); while (!in_tready);
    board.note_char(c);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(smm_pkg::CH_NUL);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (board.found_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [smm_pkg::CfgAddrW-1:0] idx,
                           input logic [smm_pkg::CfgDataW-1:0] v);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, v);
  endtask

  task automatic load_pattern(input logic [smm_pkg::PatW-1:0] chars,
                              input logic [smm_pkg::LenW-1:0] len,
                              input logic [smm_pkg::ModeW-1:0] m);
    settle();
    write_reg(smm_pkg::REG_PAT_LOW, chars[smm_pkg::CfgDataW-1:0]);
    write_reg(smm_pkg::REG_PAT_HIGH, chars[smm_pkg::PatW-1:smm_pkg::CfgDataW]);
    write_reg(smm_pkg::REG_PAT_LEN, smm_pkg::CfgDataW'(len));
    write_reg(smm_pkg::REG_MODE, smm_pkg::CfgDataW'(m));
  endtask

  function automatic logic [smm_pkg::PatW-1:0] pack_str(input string s);
    logic [smm_pkg::PatW-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < smm_pkg::PatBytes; i++)
      r[i*smm_pkg::CharW +: smm_pkg::CharW] = s[i];
    return r;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 2))
      0:       return smm_pkg::CH_SPACE;
      1:       return smm_pkg::CH_TAB;
      default: return smm_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] c;
    c = 8'(("a" + $urandom_range(0, 25)));
    return $urandom_range(0, 1) ? flip_case(c) : c;
  endfunction

  // Filler leans on pattern chars so that partial matches are common.
  function automatic logic [7:0] filler(input logic [smm_pkg::PatW-1:0] pat, input int len);
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && len > 0 && len <= smm_pkg::PatBytes) begin
      c = pat[$urandom_range(0, len - 1)*smm_pkg::CharW +: smm_pkg::CharW];
      if (c == smm_pkg::CH_NUL) c = "q";
      return $urandom_range(0, 1) ? flip_case(c) : c;
    end
    if (r < 7) return letter();
    if (r == 7) return space_char();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic random_text(input logic [smm_pkg::PatW-1:0] pat, input int len,
                             input bit fold);
    logic [7:0] s [$];
    logic [7:0] c;
    int n;
    n = $urandom_range(0, 4);
    repeat (n) s.push_back(filler(pat, len));
    if ($urandom_range(0, 9) < 6 && len >= 1 && len <= smm_pkg::PatBytes) begin
      for (int k = 0; k < len; k++) begin
        c = pat[k*smm_pkg::CharW +: smm_pkg::CharW];
        if (c == smm_pkg::CH_NUL) c = "z";
        if ((fold || $urandom_range(0, 7) == 0) && $urandom_range(0, 1)) c = flip_case(c);
        s.push_back(c);
      end
      if ($urandom_range(0, 6) == 0) void'(s.pop_back());  // broken occurrence
      if ($urandom_range(0, 1)) s.push_back(space_char());
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4);
    repeat (n) s.push_back(filler(pat, len));
    foreach (s[i]) send_char(s[i]);
    send_char(smm_pkg::CH_NUL);
  endtask

  initial begin
    logic [smm_pkg::PatW-1:0]  pat;
    logic [smm_pkg::ModeW-1:0] m;
    int                        len, start, r;
    bit                        first;

    board = new();
    in_idle_pct = 16;
    out_idle_pct = 79;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty pattern and empty string after reset
    send_str("");
    load_pattern(pack_str("aZ"), 5'd2, MODE_SENS);
    send_char(8'h01);
    send_str("aZ");
    send_str("Az");
    load_pattern(pack_str("aZ"), 5'd2, MODE_NOCASE);
    send_str("AZ");
    load_pattern(pack_str("aZ"), 5'd2, MODE_EXACT);
    send_str("aZ\tq");
    send_str("aZb");
    // exact match closed by the terminator itself
    load_pattern(pack_str("aZ"), 5'd2, MODE_EXACT_NOCASE);
    send_str("xAz");
    // high bytes are never folded
    load_pattern({smm_pkg::PatBytes{8'hFF}}, 5'd1, MODE_NOCASE);
    send_char(8'hFF);
    send_char(smm_pkg::CH_NUL);
    load_pattern(pack_str("aZ"), 5'd17, MODE_SENS);
    send_str("aZ");
    load_pattern({smm_pkg::PatBytes{8'hFF}}, 5'd31, MODE_EXACT_NOCASE);
    send_char(8'hFF);
    send_char(smm_pkg::CH_NUL);
    // zero byte inside the pattern can never match
    load_pattern({{(smm_pkg::PatW-16){1'b0}}, 8'h61, 8'h00}, 5'd2, MODE_SENS);
    send_str("xa");

    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin in_idle_pct = 16; out_idle_pct = 79; end
        1: begin in_idle_pct = 79; out_idle_pct = 16; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      start = words_sent;
      first = 1'b1;
      while (words_sent - start < RANDOM_WORDS / 3) begin
        for (int k = 0; k < smm_pkg::PatBytes; k++)
          pat[k*smm_pkg::CharW +: smm_pkg::CharW] =
              ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : letter();
        r = $urandom_range(0, 19);
        if (r == 0) len = 0;
        else if (r == 1) len = $urandom_range(smm_pkg::PatBytes + 1, 31);
        else if (r < 4) len = $urandom_range(5, smm_pkg::PatBytes);
        else len = $urandom_range(1, 4);
        m = smm_pkg::ModeW'($urandom_range(0, 3));
        load_pattern(pat, smm_pkg::LenW'(len), m);
        if (first) begin
          hold_token++;  // receiver stalls while short strings keep coming
          first = 1'b0;
        end
        repeat ($urandom_range(6, 14))
          if (words_sent - start < RANDOM_WORDS / 3)
            random_text(pat, len, m[smm_pkg::MODE_FOLD_BIT]);
      end
    end

    in_tvalid = 1'b0;
    while (board.found_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.found_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
